// ----- rtl/csm_pkg.sv -----
// csm_pkg: shared widths, register and mode codes, and fixed-point helpers
// for the control surface mixer with slew limiting.
// No dependencies; imported by csm_mix, csm_slew and the top level.
`default_nettype none

package csm_pkg;

  // fixed-point formats
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CMD_FRAC_BITS   = 14;

  // port field widths
  localparam int CMD_W     = 16;
  localparam int US_W      = 20;
  localparam int OUT_DEG_W = 10;
  localparam int MASK_W    = 5;
  localparam int RATE_W    = 12;
  localparam int MODE_W    = 2;
  localparam int INV_W     = 4;
  localparam int PACK_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // internal datapath widths
  localparam int MIX_W = CMD_W + 1;               // sum or difference of two commands
  localparam int PRD_W = MIX_W + BYTE_W + 1;      // command times unsigned byte
  localparam int DEG_W = BYTE_W + 3;              // neutral plus signed deflection
  localparam int ANG_W = OUT_DEG_W + ANGLE_FRAC_BITS;

  // slew step: prod * 2^ANGLE_FRAC_BITS / 10^6 = (prod << SLEW_SHIFT) / SLEW_DIV
  localparam int SLEW_SHIFT = ANGLE_FRAC_BITS - 6;
  localparam longint unsigned SLEW_DIV = 64'd1000000 >> 6;
  localparam int DIV_W  = $clog2(SLEW_DIV + 1);
  localparam int PROD_W = RATE_W + US_W;
  localparam int X_W    = PROD_W + SLEW_SHIFT;
  localparam int MD_W   = X_W - (DIV_W - 1);
  // reciprocal scaled by 2^(PROD_W + SLEW_SHIFT), rounded down
  localparam longint unsigned RECIP_M = (64'd1 << (PROD_W + SLEW_SHIFT)) / SLEW_DIV;
  localparam int RECIP_W = $clog2(RECIP_M + 1);
  localparam int RECIP_SHIFT = PROD_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP_M);
  localparam logic [DIV_W-1:0]   DIV_V   = DIV_W'(SLEW_DIV);

  localparam int SUM_W = ((DEG_W + ANGLE_FRAC_BITS) > (MD_W + 1) ?
                          (DEG_W + ANGLE_FRAC_BITS) : (MD_W + 1)) + 1;

  localparam logic signed [ANG_W-1:0] ANGLE_RESET = ANG_W'(90 << ANGLE_FRAC_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AIRFRAME_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_SURFACES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFLECTION    = 3'd5;

  // airframe modes
  localparam logic [MODE_W-1:0] MODE_CONV  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELTA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VTAIL = 2'd2;

  // byte lanes of packed registers and bits of invert_mask
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_LEFT  = 2;
  localparam int LANE_RIGHT = 3;

  // written mask bits
  localparam int MSK_ELEV   = 0;
  localparam int MSK_RUD    = 1;
  localparam int MSK_LEFT   = 2;
  localparam int MSK_RIGHT  = 3;
  localparam int MSK_SHARED = 4;

  // register reset values
  localparam logic [MODE_W-1:0] RST_MODE     = MODE_CONV;
  localparam logic              RST_DUAL     = 1'b1;
  localparam logic [RATE_W-1:0] RST_RATE     = 12'd500;
  localparam logic [INV_W-1:0]  RST_INV      = 4'd0;
  localparam logic [PACK_W-1:0] RST_NEUTRAL  = 32'h5A5A_5A5A;
  localparam logic [PACK_W-1:0] RST_DEFL     = 32'h5050_5050;

  // desired whole-degree angles of all servos and which of them are driven
  typedef struct packed {
    logic signed [DEG_W-1:0] elev;
    logic signed [DEG_W-1:0] rud;
    logic signed [DEG_W-1:0] left;
    logic signed [DEG_W-1:0] right;
    logic signed [DEG_W-1:0] shared;
    logic [MASK_W-1:0]       mask;
  } mix_t;

  // clamp a command to +/-1.0
  function automatic logic signed [CMD_W-1:0] csm_sat(input logic signed [CMD_W-1:0] c);
    logic signed [CMD_W-1:0] one;
    one = CMD_W'(1 << CMD_FRAC_BITS);
    if (c > one) return one;
    else if (c < -one) return -one;
    else return c;
  endfunction

  // cmd * defl scaled down, truncated toward zero; mixes get one more halving
  function automatic logic signed [DEG_W-1:0] csm_deflect(
    input logic signed [MIX_W-1:0] c,
    input logic [BYTE_W-1:0] defl,
    input logic mixed
  );
    logic signed [PRD_W-1:0] p;
    logic signed [PRD_W-1:0] bias;
    logic signed [PRD_W-1:0] q;
    p = PRD_W'(c) * PRD_W'($signed({1'b0, defl}));
    if (p < 0) begin
      bias = mixed ? PRD_W'((1 << (CMD_FRAC_BITS + 1)) - 1) : PRD_W'((1 << CMD_FRAC_BITS) - 1);
    end else begin
      bias = '0;
    end
    q = mixed ? ((p + bias) >>> (CMD_FRAC_BITS + 1)) : ((p + bias) >>> CMD_FRAC_BITS);
    return q[DEG_W-1:0];
  endfunction

  // neutral plus or minus a deflection
  function automatic logic signed [DEG_W-1:0] csm_place(
    input logic [BYTE_W-1:0] n,
    input logic signed [DEG_W-1:0] v,
    input logic neg
  );
    logic signed [DEG_W-1:0] ns;
    ns = signed'(DEG_W'(n));
    return neg ? (ns - v) : (ns + v);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/csm_mix.sv -----
// csm_mix: command saturation and airframe mixing into desired servo angles.
// Combinational; depends on csm_pkg.
`default_nettype none

module csm_mix (
  input  logic signed [csm_pkg::CMD_W-1:0]  roll_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]  pitch_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]  yaw_cmd,
  input  logic [csm_pkg::MODE_W-1:0]        airframe_mode,
  input  logic                              dual_surfaces,
  input  logic [csm_pkg::INV_W-1:0]         invert_mask,
  input  logic [csm_pkg::PACK_W-1:0]        neutral_packed,
  input  logic [csm_pkg::PACK_W-1:0]        deflection_packed,
  output csm_pkg::mix_t                     mix
);
  import csm_pkg::*;

  logic signed [CMD_W-1:0] roll_s, pitch_s, yaw_s;
  logic signed [MIX_W-1:0] lmix, rmix, lop;
  logic                    conv;
  logic signed [DEG_W-1:0] dp, dy, dl, dr;
  logic [BYTE_W-1:0]       n_p, n_y, n_l, n_r;

  assign roll_s  = csm_sat(roll_cmd);
  assign pitch_s = csm_sat(pitch_cmd);
  assign yaw_s   = csm_sat(yaw_cmd);
  assign conv    = (airframe_mode == MODE_CONV);

  assign n_p = neutral_packed[LANE_PITCH*BYTE_W +: BYTE_W];
  assign n_y = neutral_packed[LANE_YAW*BYTE_W +: BYTE_W];
  assign n_l = neutral_packed[LANE_LEFT*BYTE_W +: BYTE_W];
  assign n_r = neutral_packed[LANE_RIGHT*BYTE_W +: BYTE_W];

  always_comb begin
    if (airframe_mode == MODE_DELTA) begin
      lmix = MIX_W'(pitch_s) - MIX_W'(roll_s);
      rmix = MIX_W'(pitch_s) + MIX_W'(roll_s);
    end else begin
      lmix = MIX_W'(pitch_s) + MIX_W'(yaw_s);
      rmix = MIX_W'(pitch_s) - MIX_W'(yaw_s);
    end
  end

  // left lane carries roll in conventional mode, the left mix otherwise
  assign lop = conv ? MIX_W'(roll_s) : lmix;

  assign dp = csm_deflect(MIX_W'(pitch_s),
                          deflection_packed[LANE_PITCH*BYTE_W +: BYTE_W], 1'b0);
  assign dy = csm_deflect(MIX_W'(yaw_s),
                          deflection_packed[LANE_YAW*BYTE_W +: BYTE_W], 1'b0);
  assign dl = csm_deflect(lop, deflection_packed[LANE_LEFT*BYTE_W +: BYTE_W], !conv);
  assign dr = csm_deflect(rmix, deflection_packed[LANE_RIGHT*BYTE_W +: BYTE_W], 1'b1);

  always_comb begin
    mix        = '0;
    mix.elev   = csm_place(n_p, dp, invert_mask[LANE_PITCH]);
    mix.rud    = csm_place(n_y, dy, invert_mask[LANE_YAW]);
    mix.left   = csm_place(n_l, dl, invert_mask[LANE_LEFT]);
    mix.shared = csm_place(n_l, dl, invert_mask[LANE_LEFT]);
    unique case (airframe_mode)
      MODE_CONV: begin
        // right aileron is reversed unless its own invert flag undoes it
        mix.right = csm_place(n_r, dl, !invert_mask[LANE_RIGHT]);
        mix.mask[MSK_ELEV]   = 1'b1;
        mix.mask[MSK_RUD]    = 1'b1;
        mix.mask[MSK_LEFT]   = dual_surfaces;
        mix.mask[MSK_RIGHT]  = dual_surfaces;
        mix.mask[MSK_SHARED] = !dual_surfaces;
      end
      MODE_DELTA, MODE_VTAIL: begin
        mix.right = csm_place(n_r, dr, invert_mask[LANE_RIGHT]);
        mix.mask[MSK_LEFT]  = 1'b1;
        mix.mask[MSK_RIGHT] = 1'b1;
      end
      default: begin
        mix.right = csm_place(n_r, dr, invert_mask[LANE_RIGHT]);
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/csm_slew.sv -----
// csm_slew: clamps one surface's desired angle to within a step of its last
// angle and gives the whole-degree value; combinational, depends on csm_pkg.
`default_nettype none

module csm_slew (
  input  logic signed [csm_pkg::ANG_W-1:0]     last_angle,
  input  logic signed [csm_pkg::DEG_W-1:0]     desired,
  input  logic [csm_pkg::MD_W-1:0]             max_step,
  output logic signed [csm_pkg::ANG_W-1:0]     angle_nxt,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] deg
);
  import csm_pkg::*;

  localparam logic signed [ANG_W-1:0] FRAC_ONES = ANG_W'((1 << ANGLE_FRAC_BITS) - 1);

  logic signed [SUM_W-1:0] lo, hi, d, d_c;
  logic signed [ANG_W-1:0] res, bias, whole;

  assign lo = SUM_W'(last_angle) - signed'(SUM_W'(max_step));
  assign hi = SUM_W'(last_angle) + signed'(SUM_W'(max_step));
  assign d  = SUM_W'(desired) <<< ANGLE_FRAC_BITS;

  always_comb begin
    priority if (d < lo) begin
      d_c = lo;
    end else if (d > hi) begin
      d_c = hi;
    end else begin
      d_c = d;
    end
  end

  // clamped value lies between last and desired, so it stays in range
  assign res       = d_c[ANG_W-1:0];
  assign angle_nxt = res;

  // whole degrees, truncated toward zero
  assign bias  = (res < 0) ? FRAC_ONES : '0;
  assign whole = (res + bias) >>> ANGLE_FRAC_BITS;
  assign deg   = whole[OUT_DEG_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/control_surface_mixer_slew_unit.sv -----
// control_surface_mixer_slew_unit: top level of the servo mixer with slew limiting.
// Depends on csm_pkg, csm_mix and csm_slew.
`default_nettype none

// Takes roll, pitch and yaw commands (Q2.14) plus the elapsed microseconds and
// returns one set of servo angles per request. Throughput is one request per
// clock while the output register is not stalled. A request passes an input
// register, a mixing stage (four small deflection multiplies and the 12x20
// rate-by-time product), a reciprocal multiply stage, a remainder correction
// stage that yields the slew step, and the output register where the five
// slew limiters update their held angles. All stages advance together, so
// in_ready drops only while a finished result waits in the output register.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// must only happen while no request is in flight. Unwritten servos read zero.
module control_surface_mixer_slew_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_roll_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_pitch_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_yaw_cmd,
  input  logic [csm_pkg::US_W-1:0]             in_elapsed_us,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] out_elevator_deg,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] out_rudder_deg,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] out_left_deg,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] out_right_deg,
  output logic signed [csm_pkg::OUT_DEG_W-1:0] out_shared_aileron_deg,
  output logic [csm_pkg::MASK_W-1:0]           out_written_mask,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csm_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import csm_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic              dual_r;
  logic [RATE_W-1:0] rate_r;
  logic [INV_W-1:0]  inv_r;
  logic [PACK_W-1:0] neutral_r;
  logic [PACK_W-1:0] defl_r;

  // pipeline valids, all advance on one enable
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv;

  // stage 1: captured request
  logic signed [CMD_W-1:0] s1_roll_r, s1_pitch_r, s1_yaw_r;
  logic [US_W-1:0]         s1_us_r;

  // stage 2: desired angles and rate-by-time product
  mix_t                    mix_c;
  mix_t                    s2_mix_r;
  logic [PROD_W-1:0]       s2_prod_r;

  // stage 3: quotient estimate
  logic [PROD_W+RECIP_W-1:0] qfull;
  mix_t                      s3_mix_r;
  logic [PROD_W-1:0]         s3_prod_r;
  logic [MD_W-1:0]           s3_qest_r;

  // stage 4: exact slew step
  logic [X_W-1:0]          x_c;
  logic [MD_W+DIV_W-1:0]   qm_full;
  logic [X_W-1:0]          rem_c;
  logic [MD_W-1:0]         md_nxt;
  mix_t                    s4_mix_r;
  logic [MD_W-1:0]         s4_md_r;

  // held surface angles
  logic signed [ANG_W-1:0] last_elev_r, last_rud_r, last_left_r, last_right_r, last_shared_r;
  logic signed [ANG_W-1:0] elev_nxt, rud_nxt, left_nxt, right_nxt, shared_nxt;
  logic signed [OUT_DEG_W-1:0] elev_deg, rud_deg, left_deg, right_deg, shared_deg;

  // output register
  logic signed [OUT_DEG_W-1:0] out_elev_r, out_rud_r, out_left_r, out_right_r, out_shared_r;
  logic [MASK_W-1:0]           out_mask_r;
  logic                        load_out;

  // whole pipeline moves unless a result is stuck in the output register
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign load_out  = adv && v4_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      dual_r    <= RST_DUAL;
      rate_r    <= RST_RATE;
      inv_r     <= RST_INV;
      neutral_r <= RST_NEUTRAL;
      defl_r    <= RST_DEFL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AIRFRAME_MODE: mode_r    <= cfg_data[MODE_W-1:0];
        REG_DUAL_SURFACES: dual_r    <= cfg_data[0];
        REG_SLEW_RATE:     rate_r    <= cfg_data[RATE_W-1:0];
        REG_INVERT_MASK:   inv_r     <= cfg_data[INV_W-1:0];
        REG_NEUTRAL:       neutral_r <= cfg_data[PACK_W-1:0];
        REG_DEFLECTION:    defl_r    <= cfg_data[PACK_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // saturation, mixing and deflection scaling
  csm_mix u_mix (
    .roll_cmd          (s1_roll_r),
    .pitch_cmd         (s1_pitch_r),
    .yaw_cmd           (s1_yaw_r),
    .airframe_mode     (mode_r),
    .dual_surfaces     (dual_r),
    .invert_mask       (inv_r),
    .neutral_packed    (neutral_r),
    .deflection_packed (defl_r),
    .mix               (mix_c)
  );

  // slew step = floor((prod << SLEW_SHIFT) / SLEW_DIV): the reciprocal
  // estimate is low by at most one, the remainder check fixes that
  assign qfull   = {{RECIP_W{1'b0}}, s2_prod_r} * {{PROD_W{1'b0}}, RECIP_V};
  assign x_c     = {s3_prod_r, {SLEW_SHIFT{1'b0}}};
  assign qm_full = {{DIV_W{1'b0}}, s3_qest_r} * {{MD_W{1'b0}}, DIV_V};
  assign rem_c   = x_c - qm_full[X_W-1:0];
  assign md_nxt  = s3_qest_r + MD_W'(rem_c >= X_W'(DIV_V));

  // data stages, no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_roll_r  <= in_roll_cmd;
      s1_pitch_r <= in_pitch_cmd;
      s1_yaw_r   <= in_yaw_cmd;
      s1_us_r    <= in_elapsed_us;
      s2_mix_r   <= mix_c;
      s2_prod_r  <= PROD_W'(rate_r) * PROD_W'(s1_us_r);
      s3_mix_r   <= s2_mix_r;
      s3_prod_r  <= s2_prod_r;
      s3_qest_r  <= qfull[RECIP_SHIFT +: MD_W];
      s4_mix_r   <= s3_mix_r;
      s4_md_r    <= md_nxt;
    end
  end

  // one slew limiter per servo against its held angle
  csm_slew u_slew_elev (
    .last_angle (last_elev_r),   .desired (s4_mix_r.elev),   .max_step (s4_md_r),
    .angle_nxt  (elev_nxt),      .deg     (elev_deg)
  );
  csm_slew u_slew_rud (
    .last_angle (last_rud_r),    .desired (s4_mix_r.rud),    .max_step (s4_md_r),
    .angle_nxt  (rud_nxt),       .deg     (rud_deg)
  );
  csm_slew u_slew_left (
    .last_angle (last_left_r),   .desired (s4_mix_r.left),   .max_step (s4_md_r),
    .angle_nxt  (left_nxt),      .deg     (left_deg)
  );
  csm_slew u_slew_right (
    .last_angle (last_right_r),  .desired (s4_mix_r.right),  .max_step (s4_md_r),
    .angle_nxt  (right_nxt),     .deg     (right_deg)
  );
  csm_slew u_slew_shared (
    .last_angle (last_shared_r), .desired (s4_mix_r.shared), .max_step (s4_md_r),
    .angle_nxt  (shared_nxt),    .deg     (shared_deg)
  );

  // held angles move only for servos this request writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_elev_r   <= ANGLE_RESET;
      last_rud_r    <= ANGLE_RESET;
      last_left_r   <= ANGLE_RESET;
      last_right_r  <= ANGLE_RESET;
      last_shared_r <= ANGLE_RESET;
    end else if (load_out) begin
      if (s4_mix_r.mask[MSK_ELEV])   last_elev_r   <= elev_nxt;
      if (s4_mix_r.mask[MSK_RUD])    last_rud_r    <= rud_nxt;
      if (s4_mix_r.mask[MSK_LEFT])   last_left_r   <= left_nxt;
      if (s4_mix_r.mask[MSK_RIGHT])  last_right_r  <= right_nxt;
      if (s4_mix_r.mask[MSK_SHARED]) last_shared_r <= shared_nxt;
    end
  end

  // output register; servos not written report zero
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_elev_r   <= s4_mix_r.mask[MSK_ELEV]   ? elev_deg   : '0;
      out_rud_r    <= s4_mix_r.mask[MSK_RUD]    ? rud_deg    : '0;
      out_left_r   <= s4_mix_r.mask[MSK_LEFT]   ? left_deg   : '0;
      out_right_r  <= s4_mix_r.mask[MSK_RIGHT]  ? right_deg  : '0;
      out_shared_r <= s4_mix_r.mask[MSK_SHARED] ? shared_deg : '0;
      out_mask_r   <= s4_mix_r.mask;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_elevator_deg       = out_elev_r;
  assign out_rudder_deg         = out_rud_r;
  assign out_left_deg           = out_left_r;
  assign out_right_deg          = out_right_r;
  assign out_shared_aileron_deg = out_shared_r;
  assign out_written_mask       = out_mask_r;

  // the shared servo and the dual ailerons are never written together
  a_shared_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_mask_r[MSK_SHARED] &&
                      (out_mask_r[MSK_LEFT] || out_mask_r[MSK_RIGHT])))
    else $error("shared aileron written together with dual ailerons");

  // an unwritten shared aileron reads zero
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_mask_r[MSK_SHARED]) |-> (out_shared_r == '0))
    else $error("unwritten shared aileron is not zero");

  // the held elevator angle changes only when a result is loaded that writes it
  a_state_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(last_elev_r)) |->
      $past(load_out && s4_mix_r.mask[MSK_ELEV]))
    else $error("elevator angle changed without a write");

endmodule

`default_nettype wire

// ----- tb/csm_servo_checker.sv -----
// csm_servo_checker: watches the register, request and result channels of the
// control surface mixer, predicts every result and compares it field by field.
// Depends on csm_pkg for widths, register indexes, mode codes and reset values.
module csm_servo_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_roll_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_pitch_cmd,
  input  logic signed [csm_pkg::CMD_W-1:0]     in_yaw_cmd,
  input  logic [csm_pkg::US_W-1:0]             in_elapsed_us,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [csm_pkg::OUT_DEG_W-1:0] out_elevator_deg,
  input  logic signed [csm_pkg::OUT_DEG_W-1:0] out_rudder_deg,
  input  logic signed [csm_pkg::OUT_DEG_W-1:0] out_left_deg,
  input  logic signed [csm_pkg::OUT_DEG_W-1:0] out_right_deg,
  input  logic signed [csm_pkg::OUT_DEG_W-1:0] out_shared_aileron_deg,
  input  logic [csm_pkg::MASK_W-1:0]           out_written_mask,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csm_pkg::CFG_DAT_W-1:0]        cfg_data,
  output int                                   mismatches,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import csm_pkg::*;

  typedef struct packed {
    logic [OUT_DEG_W-1:0] elev_deg;
    logic [OUT_DEG_W-1:0] rud_deg;
    logic [OUT_DEG_W-1:0] left_deg;
    logic [OUT_DEG_W-1:0] right_deg;
    logic [OUT_DEG_W-1:0] shared_deg;
    logic [MASK_W-1:0]    mask;
  } servo_set_t;

  // register copies
  logic [MODE_W-1:0] airframe;
  logic              dual;
  logic [RATE_W-1:0] rate;
  logic [INV_W-1:0]  inv;
  logic [PACK_W-1:0] neutral;
  logic [PACK_W-1:0] defl;

  // held angles with fraction bits, indexed by written-mask bit
  logic signed [ANG_W-1:0] held [MSK_SHARED+1];

  servo_set_t angle_q [$];

  function automatic longint clamp_cmd(input logic signed [CMD_W-1:0] c);
    longint one;
    longint v;
    one = longint'(1) << CMD_FRAC_BITS;
    v = c;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  function automatic longint lane(input logic [PACK_W-1:0] word, input int idx);
    return longint'(word[idx*BYTE_W +: BYTE_W]);
  endfunction

  // truncates toward zero, mixes take one more halving
  function automatic longint travel(input longint c, input longint d, input bit mixed);
    return (c * d) / (longint'(1) << (CMD_FRAC_BITS + (mixed ? 1 : 0)));
  endfunction

  function automatic logic [OUT_DEG_W-1:0] limit_slew(input int surf, input longint want_deg,
                                                      input longint reach);
    longint one;
    longint cur;
    longint pos;
    one = longint'(1) << ANGLE_FRAC_BITS;
    cur = held[surf];
    pos = want_deg * one;
    if (pos < cur - reach) pos = cur - reach;
    if (pos > cur + reach) pos = cur + reach;
    held[surf] = ANG_W'(pos);
    return OUT_DEG_W'(pos / one);
  endfunction

  function automatic servo_set_t predict_servos(input logic signed [CMD_W-1:0] roll_in,
                                                input logic signed [CMD_W-1:0] pitch_in,
                                                input logic signed [CMD_W-1:0] yaw_in,
                                                input logic [US_W-1:0] us);
    servo_set_t r;
    longint rol, pit, yw, reach, rp, ry, rr, lt, rt, lmix, rmix;
    longint unsigned prod;
    r = '0;
    rol = clamp_cmd(roll_in);
    pit = clamp_cmd(pitch_in);
    yw = clamp_cmd(yaw_in);
    prod = rate;
    prod = prod * us;
    reach = longint'((prod << ANGLE_FRAC_BITS) / 64'd1000000);
    if (airframe == MODE_CONV) begin
      rp = travel(pit, lane(defl, LANE_PITCH), 1'b0);
      ry = travel(yw, lane(defl, LANE_YAW), 1'b0);
      rr = travel(rol, lane(defl, LANE_LEFT), 1'b0);
      if (inv[LANE_PITCH]) rp = -rp;
      if (inv[LANE_YAW]) ry = -ry;
      // right aileron is reversed unless its inversion flips it back
      lt = inv[LANE_LEFT] ? -rr : rr;
      rt = inv[LANE_RIGHT] ? rr : -rr;
      r.elev_deg = limit_slew(MSK_ELEV, lane(neutral, LANE_PITCH) + rp, reach);
      r.rud_deg = limit_slew(MSK_RUD, lane(neutral, LANE_YAW) + ry, reach);
      r.mask[MSK_ELEV] = 1'b1;
      r.mask[MSK_RUD] = 1'b1;
      if (dual) begin
        r.left_deg = limit_slew(MSK_LEFT, lane(neutral, LANE_LEFT) + lt, reach);
        r.right_deg = limit_slew(MSK_RIGHT, lane(neutral, LANE_RIGHT) + rt, reach);
        r.mask[MSK_LEFT] = 1'b1;
        r.mask[MSK_RIGHT] = 1'b1;
      end else begin
        r.shared_deg = limit_slew(MSK_SHARED, lane(neutral, LANE_LEFT) + lt, reach);
        r.mask[MSK_SHARED] = 1'b1;
      end
    end else if (airframe == MODE_DELTA || airframe == MODE_VTAIL) begin
      if (airframe == MODE_DELTA) begin
        lmix = pit - rol;
        rmix = pit + rol;
      end else begin
        lmix = pit + yw;
        rmix = pit - yw;
      end
      lt = travel(lmix, lane(defl, LANE_LEFT), 1'b1);
      rt = travel(rmix, lane(defl, LANE_RIGHT), 1'b1);
      if (inv[LANE_LEFT]) lt = -lt;
      if (inv[LANE_RIGHT]) rt = -rt;
      r.left_deg = limit_slew(MSK_LEFT, lane(neutral, LANE_LEFT) + lt, reach);
      r.right_deg = limit_slew(MSK_RIGHT, lane(neutral, LANE_RIGHT) + rt, reach);
      r.mask[MSK_LEFT] = 1'b1;
      r.mask[MSK_RIGHT] = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    servo_set_t want;
    if (!rst_n) begin
      airframe = RST_MODE;
      dual = RST_DUAL;
      rate = RST_RATE;
      inv = RST_INV;
      neutral = RST_NEUTRAL;
      defl = RST_DEFL;
      foreach (held[i]) held[i] = ANGLE_RESET;
      angle_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AIRFRAME_MODE: airframe = cfg_data[MODE_W-1:0];
          REG_DUAL_SURFACES: dual = cfg_data[0];
          REG_SLEW_RATE:     rate = cfg_data[RATE_W-1:0];
          REG_INVERT_MASK:   inv = cfg_data[INV_W-1:0];
          REG_NEUTRAL:       neutral = cfg_data[PACK_W-1:0];
          REG_DEFLECTION:    defl = cfg_data[PACK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (angle_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = angle_q.pop_front();
          check_field("elevator_deg", $signed(want.elev_deg), out_elevator_deg);
          check_field("rudder_deg", $signed(want.rud_deg), out_rudder_deg);
          check_field("left_deg", $signed(want.left_deg), out_left_deg);
          check_field("right_deg", $signed(want.right_deg), out_right_deg);
          check_field("shared_aileron_deg", $signed(want.shared_deg), out_shared_aileron_deg);
          check_field("written_mask", want.mask, out_written_mask);
        end
      end
      if (in_valid && in_ready)
        angle_q.push_back(predict_servos(in_roll_cmd, in_pitch_cmd, in_yaw_cmd,
                                         in_elapsed_us));
    end
    outstanding <= angle_q.size();
  end

endmodule

// ----- tb/tb_control_surface_mixer_slew_unit.sv -----
// tb_control_surface_mixer_slew_unit: stimulus and verdict for the servo mixer
// with slew limiting; prediction and comparison live in csm_servo_checker.
// Depends on csm_pkg, csm_servo_checker and the control_surface_mixer_slew_unit RTL.
module tb_control_surface_mixer_slew_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csm_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE  = 4;    // a phase with no random idling
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES    = 20;   // pipeline is 5 deep, leave slack

  // airframe code with no mixing: every servo left alone
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst_n;

  logic                        in_valid;
  logic                        in_ready;
  logic signed [CMD_W-1:0]     in_roll_cmd;
  logic signed [CMD_W-1:0]     in_pitch_cmd;
  logic signed [CMD_W-1:0]     in_yaw_cmd;
  logic [US_W-1:0]             in_elapsed_us;

  logic                        out_valid;
  logic                        out_ready;
  logic signed [OUT_DEG_W-1:0] out_elevator_deg;
  logic signed [OUT_DEG_W-1:0] out_rudder_deg;
  logic signed [OUT_DEG_W-1:0] out_left_deg;
  logic signed [OUT_DEG_W-1:0] out_right_deg;
  logic signed [OUT_DEG_W-1:0] out_shared_aileron_deg;
  logic [MASK_W-1:0]           out_written_mask;

  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DAT_W-1:0]        cfg_data;

  int mismatches;
  int outstanding;

  // idling knobs, percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit long_hold    = 1'b0;

  control_surface_mixer_slew_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_roll_cmd            (in_roll_cmd),
    .in_pitch_cmd           (in_pitch_cmd),
    .in_yaw_cmd             (in_yaw_cmd),
    .in_elapsed_us          (in_elapsed_us),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_elevator_deg       (out_elevator_deg),
    .out_rudder_deg         (out_rudder_deg),
    .out_left_deg           (out_left_deg),
    .out_right_deg          (out_right_deg),
    .out_shared_aileron_deg (out_shared_aileron_deg),
    .out_written_mask       (out_written_mask),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // predicts every result and counts mismatches
  csm_servo_checker servo_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_roll_cmd            (in_roll_cmd),
    .in_pitch_cmd           (in_pitch_cmd),
    .in_yaw_cmd             (in_yaw_cmd),
    .in_elapsed_us          (in_elapsed_us),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_elevator_deg       (out_elevator_deg),
    .out_rudder_deg         (out_rudder_deg),
    .out_left_deg           (out_left_deg),
    .out_right_deg          (out_right_deg),
    .out_shared_aileron_deg (out_shared_aileron_deg),
    .out_written_mask       (out_written_mask),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .mismatches             (mismatches),
    .outstanding            (outstanding)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void set_idle(input idle_mode_e m);
    case (m)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 88; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
      IDLE_BOTH:     begin tx_idle_pct = 25; rx_stall_pct = 25; end
      default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endfunction

  // one request; valid stays high afterwards unless the next call idles first
  task automatic send_cmd(input logic signed [CMD_W-1:0] roll,
                          input logic signed [CMD_W-1:0] pitch,
                          input logic signed [CMD_W-1:0] yaw,
                          input logic [US_W-1:0] us);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_roll_cmd   <= roll;
    in_pitch_cmd  <= pitch;
    in_yaw_cmd    <= yaw;
    in_elapsed_us <= us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and hold until every request has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes, caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [MODE_W-1:0] mode, input logic dual,
                             input logic [RATE_W-1:0] rate, input logic [INV_W-1:0] inv,
                             input logic [PACK_W-1:0] neutral,
                             input logic [PACK_W-1:0] defl);
    write_reg(REG_AIRFRAME_MODE, CFG_DAT_W'(mode));
    write_reg(REG_DUAL_SURFACES, CFG_DAT_W'(dual));
    write_reg(REG_SLEW_RATE, CFG_DAT_W'(rate));
    write_reg(REG_INVERT_MASK, CFG_DAT_W'(inv));
    write_reg(REG_NEUTRAL, CFG_DAT_W'(neutral));
    write_reg(REG_DEFLECTION, CFG_DAT_W'(defl));
    cfg_valid <= 1'b0;
  endtask

  // field extremes, saturation, zero and full elapsed time
  task automatic send_directed_batch();
    send_cmd(16'sh7FFF, 16'sh8000, 16'sd16385, '1);
    send_cmd(-16'sd16384, 16'sd16384, -16'sd16384, '0);
    send_cmd(16'sd16384, 16'sd16384, 16'sd16384, 20'd20000);
    send_cmd(-16'sd1, 16'sd1, 16'sh8000, 20'd1);
    send_cmd(16'sd0, 16'sd0, 16'sd0, '1);
  endtask

  function automatic logic signed [CMD_W-1:0] rand_cmd();
    case ($urandom_range(9))
      0, 1:    return CMD_W'($urandom());
      2:       return $urandom_range(1) ? CMD_W'(1 << CMD_FRAC_BITS)
                                        : CMD_W'(-(1 << CMD_FRAC_BITS));
      default: return CMD_W'(int'($urandom_range(0, 2 << CMD_FRAC_BITS))
                             - (1 << CMD_FRAC_BITS));
    endcase
  endfunction

  // mostly short frame times so slewing stays visible
  function automatic logic [US_W-1:0] rand_us();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return US_W'($urandom_range(20000));
      6, 7:       return US_W'($urandom_range(200000));
      default:    return US_W'($urandom());
    endcase
  endfunction

  task automatic load_random_config();
    logic [MODE_W-1:0] mode;
    logic [RATE_W-1:0] rate;
    logic [PACK_W-1:0] neutral;
    logic [PACK_W-1:0] defl;
    int b;
    case ($urandom_range(9))
      0:       mode = MODE_NONE;
      1, 2, 3: mode = MODE_DELTA;
      4, 5, 6: mode = MODE_VTAIL;
      default: mode = MODE_CONV;
    endcase
    case ($urandom_range(3))
      0:       rate = RATE_W'($urandom());
      1:       rate = RATE_W'($urandom_range(100, 1000));
      2:       rate = '1;
      default: rate = RATE_W'($urandom_range(1, 40));
    endcase
    // either anything at all or a plausible servo setup
    neutral = $urandom();
    defl = $urandom();
    if ($urandom_range(1)) begin
      for (b = 0; b < 4; b++) neutral[b*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(60, 120));
    end
    if ($urandom_range(1)) begin
      for (b = 0; b < 4; b++) defl[b*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(20, 90));
    end
    load_config(mode, 1'($urandom_range(1)), rate, INV_W'($urandom()), neutral, defl);
  endtask

  // result side: random stalls, or one long hold-off counted here
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p;
    int k;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_roll_cmd   = '0;
    in_pitch_cmd  = '0;
    in_yaw_cmd    = '0;
    in_elapsed_us = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, first with the register reset values
    set_idle(IDLE_NONE);
    send_directed_batch();
    wait_drained();
    // conventional with one shared aileron, everything inverted, lowest angles
    load_config(MODE_CONV, 1'b0, '1, '1, '0, '1);
    send_directed_batch();
    wait_drained();
    // elevons with zero slew rate: surfaces never move
    load_config(MODE_DELTA, 1'b1, '0, 4'b0101, '1, 32'h8080_8080);
    send_directed_batch();
    wait_drained();
    // ruddervators at the top of the angle range
    load_config(MODE_VTAIL, 1'b0, '1, 4'b1010, '1, '1);
    send_directed_batch();
    wait_drained();
    // unknown airframe: nothing written, all fields zero
    load_config(MODE_NONE, 1'b1, 12'd1, '0, RST_NEUTRAL, '0);
    send_directed_batch();
    wait_drained();

    // random phases, each with fresh settings and its own idling pattern
    for (p = 0; p < NUM_PHASES; p++) begin
      set_idle(idle_mode_e'(p % 4));
      load_random_config();
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == PRESSURE_PHASE && k == 20) begin
          // receiver holds off while requests keep coming, pipeline backs up
          long_hold = 1'b1;
        end
        if (p == PRESSURE_PHASE && k == 60) begin
          // sender pauses mid-phase until every result is back
          wait_drained();
        end
        send_cmd(rand_cmd(), rand_cmd(), rand_cmd(), rand_us());
      end
      wait_drained();
    end

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
